[design/bmp565_pkg.sv]
// Shared types and constants for the BMP 24-bit to RGB565 stream decoder.
// Used by the decoder core, the result queue and the top level; no dependencies.
package bmp565_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DRAIN
  } phase_t;

  typedef enum logic [2:0] {
    KIND_PIXEL       = 3'd0,
    KIND_DONE        = 3'd1,
    KIND_OFFSCREEN   = 3'd2,
    KIND_NOT_BMP     = 3'd3,
    KIND_UNSUPPORTED = 3'd4,
    KIND_BAD_OFFSET  = 3'd5,
    KIND_TRUNCATED   = 3'd6
  } kind_t;

  typedef struct packed {
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] pixel_color;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic        end_of_run;
  } result_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

  localparam logic [31:0] BMP_SIGNATURE  = 32'h0000_4D42;
  localparam logic [31:0] BMP_PLANES     = 32'd1;
  localparam logic [31:0] BMP_BPP        = 32'd24;
  localparam logic [31:0] HEADER_END     = 32'd34;

  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = $clog2(RES_DEPTH);

  function automatic result_t status_result(input kind_t k);
    result_t r;
    r             = '0;
    r.kind        = k;
    return r;
  endfunction

endpackage

[design/bmp565_core.sv]
// Decoder core: header parsing, offset skip, pixel and padding tracking and
// RGB565 packing. Produces up to two results per byte. Depends on bmp565_pkg.
module bmp565_core
  import bmp565_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] file_byte,
  input  logic       last_byte,
  input  cfg_t       cfg,
  output logic [1:0] wr_count,
  output result_t    wr0,
  output result_t    wr1
);

  localparam logic [31:0] POS_SIG_END    = 32'd1;
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_WIDTH_END  = 32'd21;
  localparam logic [31:0] POS_HEIGHT_END = 32'd25;
  localparam logic [31:0] POS_PLANES_END = 32'd27;
  localparam logic [31:0] POS_BPP_END    = 32'd29;
  localparam logic [31:0] POS_COMP_END   = 32'd33;

  phase_t      phase, phase_next;
  logic [31:0] byte_pos, byte_pos_next;
  logic [1:0]  field_idx, field_idx_next;
  logic [31:0] field_value, field_value_next;
  logic [31:0] data_offset, data_offset_next;
  logic [15:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;
  logic [1:0]  pad_count, pad_count_next;
  logic [1:0]  triple_index, triple_index_next;
  logic [7:0]  blue_hold, blue_hold_next;
  logic [7:0]  green_hold, green_hold_next;

  logic        field_start;
  logic [1:0]  eff_idx;
  logic [31:0] field_acc;
  logic [31:0] pos_inc;
  logic        offscreen;
  logic [17:0] sx;
  logic [17:0] sy;
  logic [15:0] col_inc;
  logic [15:0] row_inc;
  logic        pix_emit;
  logic        stat_emit;
  kind_t       stat_kind;
  result_t     pix;
  result_t     stat;

  assign field_start = (byte_pos == 32'd0) || (byte_pos == 32'd2) || (byte_pos == 32'd6) ||
                       (byte_pos == 32'd10) || (byte_pos == 32'd14) ||
                       (byte_pos == 32'd18) || (byte_pos == 32'd22) ||
                       (byte_pos == 32'd26) || (byte_pos == 32'd28) || (byte_pos == 32'd30);
  assign eff_idx   = field_start ? 2'd0 : field_idx;
  assign field_acc = (field_start ? 32'd0 : field_value) |
                     ({24'd0, file_byte} << {eff_idx, 3'b000});
  assign pos_inc   = byte_pos + 32'd1;
  assign offscreen = ($signed({cfg.origin_x[15], cfg.origin_x}) >=
                      $signed({5'd0, cfg.screen_width})) ||
                     ($signed({cfg.origin_y[15], cfg.origin_y}) >=
                      $signed({5'd0, cfg.screen_height}));
  assign sx = {{2{cfg.origin_x[15]}}, cfg.origin_x} + {2'd0, column_count};
  assign sy = {{2{cfg.origin_y[15]}}, cfg.origin_y} + {2'd0, image_height} - 18'd1 -
              {2'd0, row_count};
  assign col_inc = column_count + 16'd1;
  assign row_inc = row_count + 16'd1;

  always_comb begin
    phase_next        = phase;
    byte_pos_next     = byte_pos;
    field_idx_next    = field_idx;
    field_value_next  = field_value;
    data_offset_next  = data_offset;
    image_width_next  = image_width;
    image_height_next = image_height;
    column_count_next = column_count;
    row_count_next    = row_count;
    pad_count_next    = pad_count;
    triple_index_next = triple_index;
    blue_hold_next    = blue_hold;
    green_hold_next   = green_hold;
    pix_emit          = 1'b0;
    stat_emit         = 1'b0;
    stat_kind         = KIND_DONE;
    pix               = '0;
    pix.kind          = KIND_PIXEL;
    pix.pixel_color   = {file_byte[7:3], green_hold[7:2], blue_hold[7:3]};
    pix.pixel_x       = sx[11:0];
    pix.pixel_y       = sy[11:0];

    unique case (phase)
      PH_HEADER: begin
        if ((byte_pos == 32'd0) && offscreen) begin
          stat_emit  = 1'b1;
          stat_kind  = KIND_OFFSCREEN;
          phase_next = PH_DRAIN;
        end else begin
          field_idx_next   = eff_idx + 2'd1;
          field_value_next = field_acc;
          unique case (byte_pos)
            POS_SIG_END: begin
              if (field_acc != BMP_SIGNATURE) begin
                stat_emit = 1'b1;
                stat_kind = KIND_NOT_BMP;
              end
            end
            POS_OFFSET_END: data_offset_next  = field_acc;
            POS_WIDTH_END:  image_width_next  = field_acc[15:0];
            POS_HEIGHT_END: image_height_next = field_acc[15:0];
            POS_PLANES_END: begin
              if (field_acc != BMP_PLANES) begin
                stat_emit = 1'b1;
                stat_kind = KIND_UNSUPPORTED;
              end
            end
            POS_BPP_END: begin
              if (field_acc != BMP_BPP) begin
                stat_emit = 1'b1;
                stat_kind = KIND_UNSUPPORTED;
              end
            end
            POS_COMP_END: begin
              if (field_acc != 32'd0) begin
                stat_emit = 1'b1;
                stat_kind = KIND_UNSUPPORTED;
              end else if (data_offset < HEADER_END) begin
                stat_emit = 1'b1;
                stat_kind = KIND_BAD_OFFSET;
              end
            end
            default: ;
          endcase
          if (stat_emit) begin
            phase_next = PH_DRAIN;
          end else begin
            byte_pos_next = pos_inc;
            if (pos_inc == HEADER_END) begin
              if (data_offset != HEADER_END) begin
                phase_next = PH_SKIP;
              end else if ((image_width == 16'd0) || (image_height == 16'd0)) begin
                stat_emit  = 1'b1;
                stat_kind  = KIND_DONE;
                phase_next = PH_DRAIN;
              end else begin
                phase_next        = PH_PIXEL;
                column_count_next = 16'd0;
                row_count_next    = 16'd0;
                triple_index_next = 2'd0;
              end
            end
          end
        end
      end
      PH_SKIP: begin
        byte_pos_next = pos_inc;
        if (pos_inc >= data_offset) begin
          if ((image_width == 16'd0) || (image_height == 16'd0)) begin
            stat_emit  = 1'b1;
            stat_kind  = KIND_DONE;
            phase_next = PH_DRAIN;
          end else begin
            phase_next        = PH_PIXEL;
            column_count_next = 16'd0;
            row_count_next    = 16'd0;
            triple_index_next = 2'd0;
          end
        end
      end
      PH_PIXEL: begin
        unique case (triple_index)
          2'd0: begin
            blue_hold_next    = file_byte;
            triple_index_next = 2'd1;
          end
          2'd1: begin
            green_hold_next   = file_byte;
            triple_index_next = 2'd2;
          end
          default: begin
            triple_index_next = 2'd0;
            pix_emit = !sx[17] && (sx[16:0] < {5'd0, cfg.screen_width}) &&
                       !sy[17] && (sy[16:0] < {5'd0, cfg.screen_height});
            column_count_next = col_inc;
            if (col_inc >= image_width) begin
              column_count_next = 16'd0;
              row_count_next    = row_inc;
              if (row_inc >= image_height) begin
                stat_emit  = 1'b1;
                stat_kind  = KIND_DONE;
                phase_next = PH_DRAIN;
              end else begin
                pad_count_next = image_width[1:0];
                if (image_width[1:0] != 2'd0) begin
                  phase_next = PH_PAD;
                end
              end
            end
          end
        endcase
      end
      PH_PAD: begin
        pad_count_next = pad_count - 2'd1;
        if (pad_count == 2'd1) begin
          phase_next = PH_PIXEL;
        end
      end
      PH_DRAIN: ;
      default: ;
    endcase

    if (last_byte) begin
      if (phase_next != PH_DRAIN) begin
        stat_emit = 1'b1;
        stat_kind = KIND_TRUNCATED;
      end
      phase_next        = PH_HEADER;
      byte_pos_next     = 32'd0;
      field_idx_next    = 2'd0;
      field_value_next  = 32'd0;
      data_offset_next  = 32'd0;
      image_width_next  = 16'd0;
      image_height_next = 16'd0;
      column_count_next = 16'd0;
      row_count_next    = 16'd0;
      pad_count_next    = 2'd0;
      triple_index_next = 2'd0;
      blue_hold_next    = 8'd0;
      green_hold_next   = 8'd0;
    end

    stat            = status_result(stat_kind);
    stat.end_of_run = 1'b1;
    pix.end_of_run  = !stat_emit;

    if (pix_emit) begin
      wr0      = pix;
      wr1      = stat;
      wr_count = stat_emit ? 2'd2 : 2'd1;
    end else begin
      wr0      = stat;
      wr1      = stat;
      wr_count = {1'b0, stat_emit};
    end
    if (!take) begin
      wr_count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      byte_pos     <= 32'd0;
      field_idx    <= 2'd0;
      field_value  <= 32'd0;
      data_offset  <= 32'd0;
      image_width  <= 16'd0;
      image_height <= 16'd0;
      column_count <= 16'd0;
      row_count    <= 16'd0;
      pad_count    <= 2'd0;
      triple_index <= 2'd0;
      blue_hold    <= 8'd0;
      green_hold   <= 8'd0;
    end else if (take) begin
      phase        <= phase_next;
      byte_pos     <= byte_pos_next;
      field_idx    <= field_idx_next;
      field_value  <= field_value_next;
      data_offset  <= data_offset_next;
      image_width  <= image_width_next;
      image_height <= image_height_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      pad_count    <= pad_count_next;
      triple_index <= triple_index_next;
      blue_hold    <= blue_hold_next;
      green_hold   <= green_hold_next;
    end
  end

endmodule

[design/bmp565_res_fifo.sv]
// Result queue: takes up to two results per cycle and presents one per cycle
// to the output stream whenever that stream reads. Depends on bmp565_pkg.
module bmp565_res_fifo
  import bmp565_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] wr_count,
  input  result_t    wr0,
  input  result_t    wr1,
  input  logic       rd,
  output logic       out_valid,
  output result_t    head,
  output logic       room
);

  result_t                mem [RES_DEPTH];
  logic [RES_AW-1:0]      wr_ptr;
  logic [RES_AW-1:0]      rd_ptr;
  logic [RES_AW:0]        count;
  logic [RES_AW:0]        count_next;
  logic                   pop;

  assign pop        = rd && out_valid;
  assign out_valid  = (count != '0);
  assign head       = mem[rd_ptr];
  assign room       = (count <= (RES_AW + 1)'(RES_DEPTH - 2));
  assign count_next = count + {{(RES_AW - 1){1'b0}}, wr_count} - {{RES_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (wr_count != 2'd0) begin
      mem[wr_ptr] <= wr0;
    end
    if (wr_count == 2'd2) begin
      mem[RES_AW'(wr_ptr + 1'b1)] <= wr1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= RES_AW'(wr_ptr + wr_count);
      if (pop) begin
        rd_ptr <= RES_AW'(rd_ptr + 1'b1);
      end
      count <= count_next;
    end
  end

endmodule

[design/bmp24_to_rgb565_stream_decoder.sv]
// Accepts one BMP file byte per clock unless held back, and registers it
// before decoding. A byte is held back only while the four-entry result
// queue has fewer than two free entries, so the output side sets the
// sustained rate. Configuration comes from a plain write port; the user
// must write it between files to apply it to the next file; the block does
// not enforce this. Depends on bmp565_pkg, bmp565_core and bmp565_res_fifo.
module bmp24_to_rgb565_stream_decoder
  import bmp565_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // file_byte
  input  logic                 s_axis_tlast,  // last_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // pixel_color, pixel_x, pixel_y
  output logic [2:0]           m_axis_tuser,  // kind
  output logic                 m_axis_tlast   // end_of_run
);

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       room;
  logic       take;
  logic [1:0] wr_count;
  result_t    wr0;
  result_t    wr1;
  result_t    head;

  assign take          = in_valid && room;
  assign s_axis_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x      <= 16'd0;
      cfg.origin_y      <= 16'd0;
      cfg.screen_width  <= 12'd240;
      cfg.screen_height <= 12'd320;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      cfg.origin_x      <= cfg_data;
        REG_ORIGIN_Y:      cfg.origin_y      <= cfg_data;
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[11:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[11:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  bmp565_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .file_byte (in_byte),
    .last_byte (in_last),
    .cfg       (cfg),
    .wr_count  (wr_count),
    .wr0       (wr0),
    .wr1       (wr1)
  );

  bmp565_res_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_count  (wr_count),
    .wr0       (wr0),
    .wr1       (wr1),
    .rd        (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .head      (head),
    .room      (room)
  );

  assign m_axis_tdata = {head.pixel_y, head.pixel_x, head.pixel_color};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.end_of_run;

endmodule
